// ----- rtl/shift_rotate_compare_unit_core_macros.svh -----
// Assertion macros shared by the shift/rotate/compare unit RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SHIFT_ROTATE_COMPARE_UNIT_CORE_MACROS_SVH
`define SHIFT_ROTATE_COMPARE_UNIT_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SRCU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define SRCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/srcu_pkg.sv -----
// Package for the shift/rotate/compare unit: operation codes, word types.
// No dependencies; used by the interfaces and all modules.
package srcu_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned FUNC_W = 5;
	localparam int unsigned AMT_W  = 5;

	typedef enum logic [FUNC_W-1:0] {
		OP_SHLL    = 5'd0,
		OP_DT      = 5'd1,
		OP_SHAL    = 5'd2,
		OP_SHLR    = 5'd3,
		OP_CMPPZ   = 5'd4,
		OP_SHAR    = 5'd5,
		OP_ROTL    = 5'd6,
		OP_ROTCL   = 5'd7,
		OP_ROTR    = 5'd8,
		OP_CMPPL   = 5'd9,
		OP_ROTCR   = 5'd10,
		OP_SHLL2   = 5'd11,
		OP_SHLL8   = 5'd12,
		OP_SHLL16  = 5'd13,
		OP_SHLR2   = 5'd14,
		OP_SHLR8   = 5'd15,
		OP_SHLR16  = 5'd16,
		OP_SHAD    = 5'd17,
		OP_SHLD    = 5'd18
	} srcu_op_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [DATA_W-1:0] dest_value;
		logic [DATA_W-1:0] amount_value;
		logic              t_in;
	} srcu_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] dest_out;
		logic              t_out;
	} srcu_rsp_t;

endpackage

// ----- rtl/srcu_req_if.sv -----
// Request channel: valid/ready handshake carrying one instruction word.
// Depends on srcu_pkg.
interface srcu_req_if import srcu_pkg::*; ();
	logic      valid;
	logic      ready;
	srcu_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/srcu_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one result word.
// Depends on srcu_pkg.
interface srcu_rsp_if import srcu_pkg::*; ();
	logic      valid;
	logic      ready;
	srcu_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/srcu_exec.sv -----
// Combinational execute logic: shifts, rotates, decrement and zero test, sign compares.
// Depends on srcu_pkg.
module srcu_exec import srcu_pkg::*; (
	input  srcu_req_t req,
	output srcu_rsp_t rsp
);

	logic [DATA_W-1:0]   d;
	logic                msb;
	logic                lsb;
	logic [AMT_W-1:0]    n;
	logic [AMT_W:0]      rshamt;
	logic                fill;
	logic [2*DATA_W-1:0] ext;
	logic [2*DATA_W-1:0] ext_sh;
	logic [DATA_W-1:0]   dyn;
	logic [DATA_W-1:0]   dec;

	assign d   = req.dest_value;
	assign msb = d[DATA_W-1];
	assign lsb = d[0];
	assign n   = req.amount_value[AMT_W-1:0];
	assign dec = d - {{(DATA_W-1){1'b0}}, 1'b1};

	// Right shift by 32 - n; n of zero means a full-width shift.
	assign rshamt = (AMT_W+1)'(DATA_W) - {1'b0, n};
	assign fill   = (req.func == OP_SHAD) ? msb : 1'b0;
	assign ext    = {{DATA_W{fill}}, d};
	assign ext_sh = ext >> rshamt;
	assign dyn    = req.amount_value[DATA_W-1] ? ext_sh[DATA_W-1:0] : (d << n);

	always_comb begin
		rsp.dest_out = d;
		rsp.t_out    = req.t_in;
		case (req.func)
			OP_SHLL, OP_SHAL: begin
				rsp.t_out    = msb;
				rsp.dest_out = {d[DATA_W-2:0], 1'b0};
			end
			OP_DT: begin
				rsp.dest_out = dec;
				rsp.t_out    = (dec == '0);
			end
			OP_SHLR: begin
				rsp.t_out    = lsb;
				rsp.dest_out = {1'b0, d[DATA_W-1:1]};
			end
			OP_CMPPZ: rsp.t_out = ~msb;
			OP_SHAR: begin
				rsp.t_out    = lsb;
				rsp.dest_out = {msb, d[DATA_W-1:1]};
			end
			OP_ROTL: begin
				rsp.t_out    = msb;
				rsp.dest_out = {d[DATA_W-2:0], msb};
			end
			OP_ROTCL: begin
				rsp.t_out    = msb;
				rsp.dest_out = {d[DATA_W-2:0], req.t_in};
			end
			OP_ROTR: begin
				rsp.t_out    = lsb;
				rsp.dest_out = {lsb, d[DATA_W-1:1]};
			end
			OP_CMPPL: rsp.t_out = ~msb && (d != '0);
			OP_ROTCR: begin
				rsp.t_out    = lsb;
				rsp.dest_out = {req.t_in, d[DATA_W-1:1]};
			end
			OP_SHLL2:  rsp.dest_out = d << 2;
			OP_SHLL8:  rsp.dest_out = d << 8;
			OP_SHLL16: rsp.dest_out = d << 16;
			OP_SHLR2:  rsp.dest_out = d >> 2;
			OP_SHLR8:  rsp.dest_out = d >> 8;
			OP_SHLR16: rsp.dest_out = d >> 16;
			OP_SHAD, OP_SHLD: rsp.dest_out = dyn;
			default: ;
		endcase
	end

endmodule

// ----- rtl/shift_rotate_compare_unit_core.sv -----
// Top level of the shift/rotate/compare unit: input register, execute, result register.
// Depends on srcu_pkg, srcu_req_if, srcu_rsp_if, srcu_exec and the macros header.
//
//   channel | role | word                                      | accepted when
//   --------+------+-------------------------------------------+---------------------
//   req     | sink | func, dest_value, amount_value, t_in      | req.valid & req.ready
//   rsp     | src  | dest_out, t_out                           | rsp.valid & rsp.ready
//
// Each word is registered in the input register (_s1), passes through the execute
// logic and is registered in the result register (_s2), from which the result is
// offered on rsp. One word is accepted every cycle while rsp.ready stays high;
// the execute logic between the two registers sets the cycle time.
// arst_n clears both valid flags; data registers are not reset.
// A stall on rsp holds the result register and backs up into the input register;
// req.ready drops only when both stages are full and rsp is stalled.
`include "shift_rotate_compare_unit_core_macros.svh"

module shift_rotate_compare_unit_core import srcu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	srcu_req_if.sink   req,
	srcu_rsp_if.source rsp
);

	logic      valid_s1;
	srcu_req_t data_s1;
	logic      valid_s2;
	srcu_rsp_t data_s2;
	srcu_rsp_t exec_rsp;
	logic      ready_s2;
	logic      ready_s1;

	// Stage 2 takes a new word when it is empty or its word leaves this cycle.
	assign ready_s2 = !valid_s2 || rsp.ready;
	// Stage 1 takes a new word when it is empty or its word moves on.
	assign ready_s1 = !valid_s1 || ready_s2;

	assign req.ready = ready_s1;

	// Input register: load on accept, drop valid when the word moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && req.valid) begin
			data_s1 <= req.data;
		end
	end

	srcu_exec u_exec (
		.req (data_s1),
		.rsp (exec_rsp)
	);

	// Result register: advance when free, hold while rsp is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			data_s2 <= exec_rsp;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = data_s2;

	// A taken request must sit in the input register next cycle.
	`SRCU_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, req.valid && req.ready, valid_s1,
		"accepted word lost before stage 1")

	// Both stages full under a stall: no room for another word.
	`SRCU_ASSERT_SAME(a_full_blocks, clk, arst_n, valid_s1 && valid_s2 && !rsp.ready,
		!req.ready, "request taken with pipeline full")

	// Compare ops leave the destination value unchanged.
	`SRCU_ASSERT_NEXT(a_cmp_keeps_dest, clk, arst_n,
		valid_s1 && ready_s2 && (data_s1.func == OP_CMPPZ || data_s1.func == OP_CMPPL),
		rsp.data.dest_out == $past(data_s1.dest_value), "compare changed destination")

	// Fixed shifts SHLL2 and SHLR16 and dynamic shifts SHAD and SHLD pass T through.
	`SRCU_ASSERT_NEXT(a_fixed_keeps_t, clk, arst_n,
		valid_s1 && ready_s2 && (data_s1.func == OP_SHLL2 || data_s1.func == OP_SHLR16 ||
		data_s1.func == OP_SHAD || data_s1.func == OP_SHLD),
		rsp.data.t_out == $past(data_s1.t_in), "T changed by a T-preserving op")

endmodule
